// ===== rtl/lswap_pkg.sv =====
// Shared types, codes and sizes for the LIFO stack with swap.
package lswap_pkg;

  localparam int STACK_DEPTH = 2048;
  localparam int WORD_W      = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int ELEM_CNT_W  = 12;

  localparam logic [1:0] ACT_PUSH = 2'd0;
  localparam logic [1:0] ACT_POP  = 2'd1;
  localparam logic [1:0] ACT_SWAP = 2'd2;
  localparam logic [1:0] ACT_PEEK = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_SHORT    = 2'd3;

  typedef struct packed {
    logic [1:0]               action;
    logic signed [WORD_W-1:0] push_value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] popped_value;
    logic signed [WORD_W-1:0] top_value;
    logic                     top_valid;
    logic [ELEM_CNT_W-1:0]    element_count;
  } rsp_t;

endpackage

// ===== rtl/lswap_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module lswap_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/lifo_stack_with_swap_core.sv =====
// LIFO stack of signed words with push, pop, swap of the top two, and peek.
//
//   port      | dir | handshake            | word
//   ----------+-----+----------------------+------------------------------
//   cmd       | in  | cmd_valid/cmd_stall  | action, push_value
//   rsp       | out | rsp_valid/rsp_stall  | status, popped, top, count
//
// One word per cycle unless rsp stalls; a command goes through cmd_q, then rsp.
// The top two entries live in registers; deeper entries sit in a RAM whose
// registered read always holds the third entry, with a bypass on push.
// Reset empties the stack; RAM contents are left as they are.
// A stall on rsp holds the result; with cmd_q full, cmd stalls in the same cycle.
module lifo_stack_with_swap_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  lswap_pkg::cmd_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output lswap_pkg::rsp_t rsp
);
  import lswap_pkg::*;

  cmd_t                     cmd_q;
  logic                     cmd_q_valid;
  logic                     advance;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic signed [WORD_W-1:0] top0;
  logic signed [WORD_W-1:0] top0_next;
  logic signed [WORD_W-1:0] top1;
  logic signed [WORD_W-1:0] top1_next;
  logic signed [WORD_W-1:0] third;
  logic                     byp_valid;
  logic [WORD_W-1:0]        byp_data;
  logic [WORD_W-1:0]        ram_q;
  logic                     we;
  logic [ADDR_W-1:0]        waddr;
  logic [ADDR_W-1:0]        raddr;
  logic [1:0]               status_next;
  logic signed [WORD_W-1:0] popped_next;
  rsp_t                     rsp_next;

  assign advance   = cmd_q_valid && (!rsp_valid || !rsp_stall);
  assign cmd_stall = cmd_q_valid && !advance;
  assign third     = byp_valid ? byp_data : ram_q;
  assign waddr     = ADDR_W'(count - CNT_W'(2));
  assign raddr     = ADDR_W'(count_next - CNT_W'(3));

  always_comb begin
    count_next  = count;
    top0_next   = top0;
    top1_next   = top1;
    status_next = ST_OK;
    popped_next = '0;
    we          = 1'b0;
    if (advance) begin
      case (cmd_q.action)
        ACT_PUSH: begin
          if (count == CNT_W'(STACK_DEPTH)) begin
            status_next = ST_OVERFLOW;
          end else begin
            we         = (count >= CNT_W'(2));
            top1_next  = top0;
            top0_next  = cmd_q.push_value;
            count_next = count + CNT_W'(1);
          end
        end
        ACT_POP: begin
          if (count == '0) begin
            status_next = ST_EMPTY;
          end else begin
            popped_next = top0;
            top0_next   = top1;
            top1_next   = third;
            count_next  = count - CNT_W'(1);
          end
        end
        ACT_SWAP: begin
          if (count < CNT_W'(2)) begin
            status_next = ST_SHORT;
          end else begin
            top0_next = top1;
            top1_next = top0;
          end
        end
        default: begin
        end
      endcase
    end
    rsp_next.status        = status_next;
    rsp_next.popped_value  = popped_next;
    rsp_next.top_value     = (count_next != '0) ? top0_next : '0;
    rsp_next.top_valid     = (count_next != '0);
    rsp_next.element_count = ELEM_CNT_W'(count_next);
  end

  lswap_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (top1),
    .raddr (raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_q_valid <= 1'b0;
      count       <= '0;
      byp_valid   <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      if (!cmd_stall) begin
        cmd_q_valid <= cmd_valid;
      end
      count     <= count_next;
      byp_valid <= we && (waddr == raddr);
      if (advance) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!cmd_stall && cmd_valid) begin
      cmd_q <= cmd;
    end
    top0     <= top0_next;
    top1     <= top1_next;
    byp_data <= top1;
    if (advance) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_pop_dec: assert property (@(posedge clk) disable iff (rst)
    advance && cmd_q.action == ACT_POP && count != '0 |=> count == $past(count) - CNT_W'(1))
    else $error("pop did not drop one entry");

  a_refused_hold: assert property (@(posedge clk) disable iff (rst)
    advance && status_next != ST_OK |=> count == $past(count) && top0 === $past(top0))
    else $error("refused action changed the stack");

  a_top_valid: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.top_valid == (rsp.element_count != '0))
    else $error("top_valid disagrees with count");
`endif

endmodule
